FILE: sv/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants for the LFSR random permutation generator.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int IDX_W     = 4;   // position / shuffle index width
  localparam int VAL_W     = 4;   // element value width
  localparam int LFSR_W    = 16;
  localparam int DIVR_W    = 5;   // divisor i+1 reaches 16
  localparam int DIV_CNT_W = 4;   // counts LFSR_W dividend bits
  localparam int QDEPTH    = 2;   // request tokens held between front and back
  localparam int QCNT_W    = 2;

  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_STEP,
    ST_DIV,
    ST_RD,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } back_st_t;

  typedef struct packed {
    logic                start;
    logic [LFSR_W-1:0]   dividend;
    logic [DIVR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [IDX_W-1:0]    remainder;
  } div_rsp_t;

endpackage

FILE: sv/lfsr_random_permutation_top.sv
// ----------------------------------------------------------------------------
// lfsr_random_permutation_top
// Random permutation generator: Fisher-Yates shuffle on a 16-bit Galois LFSR.
// ----------------------------------------------------------------------------
// Each request beat with request high yields PERM_SIZE result beats holding
// the values 1..PERM_SIZE in shuffled order, position 0 first, with
// last_element set on the final one; a beat with request low is taken and
// dropped. Up to two requests queue ahead of the shuffle engine. Each request
// leaves the queue, fills the work store, runs PERM_SIZE-1 swaps and then
// emits its elements; the swap time is set by the remainder unit, which
// retires one dividend bit per cycle. Writing cfg_seed_value reloads the LFSR
// at once; the generator otherwise carries its state from one request to the
// next.
module lfsr_random_permutation_top #(
  parameter int PERM_SIZE = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lrp_pkg::LFSR_W-1:0]  cfg_seed_value,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_request,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lrp_pkg::IDX_W-1:0]   out_position,
  output logic [lrp_pkg::VAL_W-1:0]   out_element_value,
  output logic                        out_last_element
);
  import lrp_pkg::*;

  logic     tok_avail;
  logic     tok_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  lrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_request (in_request),
    .tok_avail  (tok_avail),
    .tok_pop    (tok_pop)
  );

  lrp_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  lrp_back #(
    .PERM_SIZE (PERM_SIZE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_seed_value    (cfg_seed_value),
    .tok_avail         (tok_avail),
    .tok_pop           (tok_pop),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_element_value (out_element_value),
    .out_last_element  (out_last_element)
  );

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_element |-> out_position == IDX_W'(PERM_SIZE - 1))
    else $error("last element flagged at wrong position");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    tok_pop |-> tok_avail)
    else $error("token popped from empty queue");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> DIVR_W'(div_rsp.remainder) < DIVR_W'(PERM_SIZE))
    else $error("swap index out of range");

  a_start_gap: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_req.start)
    else $error("remainder unit restarted while busy");

endmodule

FILE: sv/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front
// Input side: accepts request beats and queues one token per nonzero request.
// ----------------------------------------------------------------------------
module lrp_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_request,
  output logic tok_avail,
  input  logic tok_pop
);
  import lrp_pkg::*;

  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;

  assign in_stall  = (cnt_r == QCNT_W'(QDEPTH));
  assign tok_avail = (cnt_r != '0);
  // drop beats whose request bit is low
  assign push      = in_valid && !in_stall && in_request;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !tok_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && tok_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/lrp_mod.sv
// ----------------------------------------------------------------------------
// lrp_mod
// Restoring remainder unit: one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module lrp_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  lrp_pkg::div_req_t div_req,
  output lrp_pkg::div_rsp_t div_rsp
);
  import lrp_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [LFSR_W-1:0]    dvd_r;
  logic [DIVR_W-1:0]    dsr_r;
  logic [IDX_W-1:0]     rem_r;
  logic [DIVR_W-1:0]    trial;
  logic [IDX_W-1:0]     rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[LFSR_W-1]};
    if (trial >= dsr_r) begin
      rem_nxt = IDX_W'(trial - dsr_r);
    end else begin
      rem_nxt = IDX_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      cnt_r <= '1;
      dvd_r <= div_req.dividend;
      dsr_r <= div_req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      dvd_r <= {dvd_r[LFSR_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign div_rsp.done      = done_r;
  assign div_rsp.remainder = rem_r;

endmodule

FILE: sv/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back
// Shuffle engine: fills the work store, runs the Fisher-Yates swaps with the
// LFSR and the remainder unit, then streams the permutation out.
// ----------------------------------------------------------------------------
module lrp_back #(
  parameter int PERM_SIZE = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lrp_pkg::LFSR_W-1:0]    cfg_seed_value,
  input  logic                          tok_avail,
  output logic                          tok_pop,
  output lrp_pkg::div_req_t             div_req,
  input  lrp_pkg::div_rsp_t             div_rsp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrp_pkg::IDX_W-1:0]     out_position,
  output logic [lrp_pkg::VAL_W-1:0]     out_element_value,
  output logic                          out_last_element
);
  import lrp_pkg::*;

  localparam int ADDR_W = (PERM_SIZE > 1) ? $clog2(PERM_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PERM_SIZE - 1);

  back_st_t          st_r, st_nxt;
  logic [IDX_W-1:0]  cnt_r;     // fill / emit position
  logic [IDX_W-1:0]  shuf_r;    // shuffle index i
  logic [IDX_W-1:0]  j_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_nxt;

  logic [VAL_W-1:0]  mem [PERM_SIZE];
  logic [VAL_W-1:0]  rd_a_r, rd_b_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic              out_load;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_pos_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;

  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:     if (tok_avail) st_nxt = ST_FILL;
      ST_FILL:     if (cnt_r == LAST_IDX) st_nxt = ST_STEP;
      ST_STEP:     st_nxt = ST_DIV;
      ST_DIV:      if (div_rsp.done) st_nxt = ST_RD;
      ST_RD:       st_nxt = ST_SWAP_I;
      ST_SWAP_I:   st_nxt = ST_SWAP_J;
      ST_SWAP_J:   st_nxt = (shuf_r == IDX_W'(1)) ? ST_EMIT_RD : ST_STEP;
      ST_EMIT_RD:  st_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_load) begin
          st_nxt = (cnt_r == LAST_IDX) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    tok_pop          = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = cnt_r[ADDR_W-1:0];
    mem_wdata        = VAL_W'(cnt_r + IDX_W'(1));
    rd_en            = 1'b0;
    rd_addr_a        = shuf_r[ADDR_W-1:0];
    rd_addr_b        = j_r[ADDR_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = lfsr_nxt;
    div_req.divisor  = DIVR_W'(shuf_r) + DIVR_W'(1);
    out_load         = 1'b0;
    unique case (st_r)
      ST_IDLE:     tok_pop = tok_avail;
      ST_FILL:     mem_we = 1'b1;
      ST_STEP:     div_req.start = 1'b1;
      ST_DIV:      ;
      ST_RD:       rd_en = 1'b1;
      ST_SWAP_I: begin
        mem_we    = 1'b1;
        mem_waddr = shuf_r[ADDR_W-1:0];
        mem_wdata = rd_b_r;
      end
      ST_SWAP_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[ADDR_W-1:0];
        mem_wdata = rd_a_r;
      end
      ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = cnt_r[ADDR_W-1:0];
      end
      ST_EMIT_OUT: out_load = !out_valid_r || !out_stall;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      shuf_r      <= '0;
      lfsr_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        lfsr_r <= cfg_seed_value;
      end else if (st_r == ST_STEP) begin
        lfsr_r <= lfsr_nxt;
      end
      unique case (st_r)
        ST_IDLE:     cnt_r <= '0;
        ST_FILL: begin
          if (cnt_r == LAST_IDX) begin
            cnt_r  <= '0;
            shuf_r <= LAST_IDX;
          end else begin
            cnt_r <= cnt_r + IDX_W'(1);
          end
        end
        ST_SWAP_J: begin
          if (shuf_r != IDX_W'(1)) begin
            shuf_r <= shuf_r - IDX_W'(1);
          end
        end
        ST_EMIT_OUT: if (out_load) cnt_r <= cnt_r + IDX_W'(1);
        default:     ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DIV && div_rsp.done) begin
      j_r <= div_rsp.remainder;
    end
    if (out_load) begin
      out_pos_r  <= cnt_r;
      out_val_r  <= rd_a_r;
      out_last_r <= (cnt_r == LAST_IDX);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_element_value = out_val_r;
  assign out_last_element  = out_last_r;

endmodule
